@@ rtl/core/sync_ipc_rendezvous_macros.svh @@
// Assertion helpers shared by the rendezvous engine.
`ifndef SYNC_IPC_RENDEZVOUS_MACROS_SVH
`define SYNC_IPC_RENDEZVOUS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sir_pkg.sv @@
package sir_pkg;

  localparam int NUM_PROCS = 16;
  localparam int ADDR_BITS = 32;
  localparam int PW = $clog2(NUM_PROCS);
  localparam int IW = $clog2(NUM_PROCS + 1);
  localparam int FW = $clog2(NUM_PROCS + 3);
  localparam int CW = $clog2(NUM_PROCS + 1);

  localparam logic [IW-1:0] ID_NONE  = IW'(NUM_PROCS);
  localparam logic [FW-1:0] FILT_ANY = FW'(NUM_PROCS + 1);
  localparam logic [FW-1:0] FILT_INT = FW'(NUM_PROCS + 2);
  localparam logic [FW-1:0] FILT_NONE = FW'(NUM_PROCS);

  localparam logic [4:0] PEER_ANY = 5'd16;
  localparam logic [4:0] PEER_INT = 5'd17;
  localparam logic [4:0] SRC_INT  = 5'd16;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RECV = 2'd1;
  localparam logic [1:0] FUNC_POST = 2'd2;
  localparam logic [1:0] FUNC_BAD  = 2'd3;

  localparam logic [2:0] RES_COPIED  = 3'd0;
  localparam logic [2:0] RES_BLOCKED = 3'd1;
  localparam logic [2:0] RES_IRQ     = 3'd2;
  localparam logic [2:0] RES_DEAD    = 3'd3;
  localparam logic [2:0] RES_REFUSED = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CHAIN, S_SMATCH, S_SWALK,
    S_RCHK, S_RWALK, S_DELIVER, S_SCAN, S_DONE
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_DECODE, CMD_CHAIN, CMD_SMATCH,
    CMD_SWALK, CMD_RCHK, CMD_RWALK, CMD_DELIVER, CMD_SCAN
  } cmd_e;

  typedef struct packed {
    logic d_done;
    logic d_chain;
    logic d_rwalk;
    logic d_rchk;
    logic d_scan;
    logic ch_dead;
    logic ch_safe;
    logic sm_hit;
    logic sm_empty;
    logic walk_end;
    logic rc_hit;
    logic sc_end;
  } stat_t;

endpackage

@@ rtl/core/sir_ctrl.sv @@
module sir_ctrl import sir_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_e  cmd_o,
  output logic  busy_o,
  output logic  done_o
);

  phase_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o = CMD_DECODE;
        if (stat_i.d_done)       state_d = S_DONE;
        else if (stat_i.d_chain) state_d = S_CHAIN;
        else if (stat_i.d_rwalk) state_d = S_RWALK;
        else if (stat_i.d_rchk)  state_d = S_RCHK;
        else                     state_d = S_SCAN;
      end
      S_CHAIN: begin
        cmd_o = CMD_CHAIN;
        if (stat_i.ch_dead)      state_d = S_DONE;
        else if (stat_i.ch_safe) state_d = S_SMATCH;
      end
      S_SMATCH: begin
        cmd_o = CMD_SMATCH;
        if (stat_i.sm_hit)        state_d = S_DONE;
        else if (stat_i.sm_empty) state_d = S_SCAN;
        else                      state_d = S_SWALK;
      end
      S_SWALK: begin
        cmd_o = CMD_SWALK;
        if (stat_i.walk_end) state_d = S_SCAN;
      end
      S_RCHK: begin
        cmd_o   = CMD_RCHK;
        state_d = stat_i.rc_hit ? S_RWALK : S_SCAN;
      end
      S_RWALK: begin
        cmd_o = CMD_RWALK;
        if (stat_i.walk_end) state_d = S_DELIVER;
      end
      S_DELIVER: begin
        cmd_o   = CMD_DELIVER;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (stat_i.sc_end) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

@@ rtl/core/sir_dpath.sv @@
module sir_dpath import sir_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_e                 cmd_i,
  input  logic [1:0]           func_i,
  input  logic [3:0]           caller_i,
  input  logic [4:0]           peer_i,
  input  logic [ADDR_BITS-1:0] buf_addr_i,
  input  logic                 cfg_valid_i,
  input  logic [4:0]           cfg_data_i,
  output stat_t                stat_o,
  output logic [2:0]           status_o,
  output logic [ADDR_BITS-1:0] copy_from_o,
  output logic [ADDR_BITS-1:0] copy_to_o,
  output logic [4:0]           msg_source_o,
  output logic                 woken_valid_o,
  output logic [3:0]           woken_pid_o,
  output logic                 next_valid_o,
  output logic [3:0]           next_run_o
);

  mode_e                mode_q [NUM_PROCS];
  logic [IW-1:0]        tgt_q  [NUM_PROCS];
  logic [FW-1:0]        filt_q [NUM_PROCS];
  logic [ADDR_BITS-1:0] pb_q   [NUM_PROCS];
  logic [IW-1:0]        qh_q   [NUM_PROCS];
  logic [IW-1:0]        qn_q   [NUM_PROCS];
  logic                 irq_q  [NUM_PROCS];

  logic [1:0]           func_q;
  logic [3:0]           caller_q;
  logic [4:0]           peer_q;
  logic [ADDR_BITS-1:0] buf_q;
  logic [IW-1:0]        ptr_q, from_q, prev_q, qhc_q;
  logic [CW-1:0]        cnt_q;
  logic [PW-1:0]        rp_q;
  logic [4:0]           slots_q;

  logic [PW-1:0]        idx, cidx, fidx, pvidx;
  mode_e                m;
  logic [IW-1:0]        t, qh, qn, caller_id, rp_next, scan_inc;
  logic [FW-1:0]        f, filt_new;
  logic [ADDR_BITS-1:0] pb;
  logic                 irq;
  logic [CW-1:0]        lim;
  logic                 caller_ok, peer_pid, irqsrc, self_hit, ptr_valid;
  logic                 bad0, post, post_hit, busyc, go, s_bad, s_ok;
  logic                 r_go, r_bad, r_irq, r_rest, r_any_hit, r_named, d_scan;
  logic                 ch_adv, rw_found, rw_end, sw_end, sc_hit;
  stat_t                st;

  // Read port: every table is read at the walk pointer only.
  assign idx   = ptr_q[PW-1:0];
  assign cidx  = PW'(caller_q);
  assign fidx  = from_q[PW-1:0];
  assign pvidx = prev_q[PW-1:0];
  assign m     = mode_q[idx];
  assign t     = tgt_q[idx];
  assign f     = filt_q[idx];
  assign pb    = pb_q[idx];
  assign qh    = qh_q[idx];
  assign qn    = qn_q[idx];
  assign irq   = irq_q[idx];

  assign caller_id = IW'(caller_q);
  assign rp_next   = (32'(rp_q) == NUM_PROCS - 1) ? '0 : IW'(rp_q) + IW'(1);
  assign scan_inc  = (32'(ptr_q) == NUM_PROCS - 1) ? '0 : ptr_q + IW'(1);
  assign filt_new  = (peer_q == PEER_ANY) ? FILT_ANY :
                     (peer_q == PEER_INT) ? FILT_INT : FW'(peer_q);

  always_comb begin
    if (slots_q == 5'd0)                lim = CW'(1);
    else if (32'(slots_q) > NUM_PROCS)  lim = CW'(NUM_PROCS);
    else                                lim = CW'(slots_q);
  end

  always_comb begin
    caller_ok = 32'(caller_q) < NUM_PROCS;
    peer_pid  = 32'(peer_q) < NUM_PROCS;
    irqsrc    = (peer_q == PEER_ANY) || (peer_q == PEER_INT);
    self_hit  = (peer_q == 5'(caller_q));
    ptr_valid = 32'(ptr_q) < NUM_PROCS;

    bad0      = (func_q == FUNC_BAD) || !caller_ok;
    post      = !bad0 && (func_q == FUNC_POST);
    post_hit  = (m == MODE_RECV) && ((f == FILT_ANY) || (f == FILT_INT));
    busyc     = !bad0 && !post && (m != MODE_IDLE);
    go        = !bad0 && !post && (m == MODE_IDLE);
    s_bad     = go && (func_q == FUNC_SEND) && (self_hit || !peer_pid);
    s_ok      = go && (func_q == FUNC_SEND) && !(self_hit || !peer_pid);
    r_go      = go && (func_q == FUNC_RECV);
    r_bad     = r_go && (self_hit || (!peer_pid && !irqsrc));
    r_irq     = r_go && !r_bad && irq && irqsrc;
    r_rest    = r_go && !r_bad && !r_irq;
    r_any_hit = r_rest && (peer_q == PEER_ANY) && (32'(qh) < NUM_PROCS);
    r_named   = r_rest && !irqsrc;
    d_scan    = r_rest && irqsrc && !r_any_hit;

    ch_adv    = (m == MODE_SEND) && (t != caller_id) && (32'(t) < NUM_PROCS);
    sw_end    = (32'(cnt_q) == NUM_PROCS) || (32'(qn) >= NUM_PROCS);
    rw_found  = ptr_valid && (ptr_q == from_q);
    rw_end    = !ptr_valid || rw_found || (32'(cnt_q) == NUM_PROCS - 1);
    sc_hit    = (32'(ptr_q) < 32'(lim)) && (m == MODE_IDLE);

    st.d_done   = bad0 || post || busyc || s_bad || r_bad || r_irq;
    st.d_chain  = s_ok;
    st.d_rwalk  = r_any_hit;
    st.d_rchk   = r_named;
    st.d_scan   = d_scan;
    st.ch_dead  = (m == MODE_SEND) && (t == caller_id);
    st.ch_safe  = !st.ch_dead && (!ch_adv || (32'(cnt_q) == NUM_PROCS - 1));
    st.sm_hit   = (m == MODE_RECV) && ((f == FW'(caller_q)) || (f == FILT_ANY));
    st.sm_empty = !st.sm_hit && (32'(qh) >= NUM_PROCS);
    st.walk_end = (cmd_i == CMD_SWALK) ? sw_end : rw_end;
    st.rc_hit   = (m == MODE_SEND) && (t == caller_id);
    st.sc_end   = sc_hit || (32'(cnt_q) == NUM_PROCS);
  end

  assign stat_o = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PROCS; i++) begin
        mode_q[i] <= MODE_IDLE;
        tgt_q[i]  <= ID_NONE;
        filt_q[i] <= FILT_NONE;
        pb_q[i]   <= '0;
        qh_q[i]   <= ID_NONE;
        qn_q[i]   <= ID_NONE;
        irq_q[i]  <= 1'b0;
      end
      func_q        <= '0;
      caller_q      <= '0;
      peer_q        <= '0;
      buf_q         <= '0;
      ptr_q         <= '0;
      from_q        <= ID_NONE;
      prev_q        <= ID_NONE;
      qhc_q         <= ID_NONE;
      cnt_q         <= '0;
      rp_q          <= '0;
      slots_q       <= 5'd7;
      status_o      <= '0;
      copy_from_o   <= '0;
      copy_to_o     <= '0;
      msg_source_o  <= '0;
      woken_valid_o <= 1'b0;
      woken_pid_o   <= '0;
      next_valid_o  <= 1'b0;
      next_run_o    <= '0;
    end else begin
      if (cfg_valid_i) slots_q <= cfg_data_i;
      case (cmd_i)
        CMD_LOAD: begin
          func_q        <= func_i;
          caller_q      <= caller_i;
          peer_q        <= peer_i;
          buf_q         <= buf_addr_i;
          ptr_q         <= IW'(caller_i);
          status_o      <= RES_REFUSED;
          copy_from_o   <= '0;
          copy_to_o     <= '0;
          msg_source_o  <= '0;
          woken_valid_o <= 1'b0;
          woken_pid_o   <= '0;
          next_valid_o  <= 1'b0;
          next_run_o    <= '0;
        end
        CMD_DECODE: begin
          if (post) begin
            if (post_hit) begin
              status_o      <= RES_IRQ;
              copy_to_o     <= pb;
              msg_source_o  <= SRC_INT;
              mode_q[cidx]  <= MODE_IDLE;
              tgt_q[cidx]   <= ID_NONE;
              filt_q[cidx]  <= FILT_NONE;
              pb_q[cidx]    <= '0;
              woken_valid_o <= 1'b1;
              woken_pid_o   <= 4'(caller_q);
            end else begin
              irq_q[cidx] <= 1'b1;
              status_o    <= RES_BLOCKED;
            end
          end
          if (busyc) status_o <= RES_BLOCKED;
          if (r_irq) begin
            irq_q[cidx]  <= 1'b0;
            status_o     <= RES_IRQ;
            copy_to_o    <= buf_q;
            msg_source_o <= SRC_INT;
          end
          if (s_ok) begin
            ptr_q <= IW'(peer_q);
            cnt_q <= '0;
          end
          if (r_any_hit) begin
            from_q <= qh;
            ptr_q  <= qh;
            prev_q <= ID_NONE;
            cnt_q  <= '0;
          end
          if (r_named) begin
            ptr_q <= IW'(peer_q);
            qhc_q <= qh;
          end
          if (d_scan) begin
            mode_q[cidx] <= MODE_RECV;
            pb_q[cidx]   <= buf_q;
            filt_q[cidx] <= filt_new;
            status_o     <= RES_BLOCKED;
            ptr_q        <= rp_next;
            cnt_q        <= CW'(1);
          end
        end
        CMD_CHAIN: begin
          if (st.ch_dead) begin
            status_o <= RES_DEAD;
          end else if (st.ch_safe) begin
            ptr_q <= IW'(peer_q);
          end else begin
            ptr_q <= t;
            cnt_q <= cnt_q + CW'(1);
          end
        end
        CMD_SMATCH: begin
          if (st.sm_hit) begin
            status_o      <= RES_COPIED;
            copy_from_o   <= buf_q;
            copy_to_o     <= pb;
            msg_source_o  <= 5'(caller_q);
            mode_q[idx]   <= MODE_IDLE;
            tgt_q[idx]    <= ID_NONE;
            filt_q[idx]   <= FILT_NONE;
            pb_q[idx]     <= '0;
            woken_valid_o <= 1'b1;
            woken_pid_o   <= 4'(idx);
          end else begin
            mode_q[cidx] <= MODE_SEND;
            tgt_q[cidx]  <= ptr_q;
            pb_q[cidx]   <= buf_q;
            qn_q[cidx]   <= ID_NONE;
            status_o     <= RES_BLOCKED;
            if (st.sm_empty) begin
              qh_q[idx] <= caller_id;
              ptr_q     <= rp_next;
              cnt_q     <= CW'(1);
            end else begin
              ptr_q <= qh;
              cnt_q <= '0;
            end
          end
        end
        CMD_SWALK: begin
          if (sw_end) begin
            qn_q[idx] <= caller_id;
            ptr_q     <= rp_next;
            cnt_q     <= CW'(1);
          end else begin
            ptr_q <= qn;
            cnt_q <= cnt_q + CW'(1);
          end
        end
        CMD_RCHK: begin
          if (st.rc_hit) begin
            from_q <= ptr_q;
            ptr_q  <= qhc_q;
            prev_q <= ID_NONE;
            cnt_q  <= '0;
          end else begin
            mode_q[cidx] <= MODE_RECV;
            pb_q[cidx]   <= buf_q;
            filt_q[cidx] <= filt_new;
            status_o     <= RES_BLOCKED;
            ptr_q        <= rp_next;
            cnt_q        <= CW'(1);
          end
        end
        CMD_RWALK: begin
          // Unlink the chosen sender from the caller's queue.
          if (rw_found) begin
            if (32'(prev_q) < NUM_PROCS) qn_q[pvidx] <= qn;
            else                         qh_q[cidx]  <= qn;
          end
          if (rw_end) begin
            qn_q[fidx] <= ID_NONE;
            ptr_q      <= from_q;
          end else begin
            prev_q <= ptr_q;
            ptr_q  <= qn;
            cnt_q  <= cnt_q + CW'(1);
          end
        end
        CMD_DELIVER: begin
          status_o      <= RES_COPIED;
          copy_from_o   <= pb;
          copy_to_o     <= buf_q;
          msg_source_o  <= 5'(from_q);
          mode_q[fidx]  <= MODE_IDLE;
          tgt_q[fidx]   <= ID_NONE;
          filt_q[fidx]  <= FILT_NONE;
          pb_q[fidx]    <= '0;
          woken_valid_o <= 1'b1;
          woken_pid_o   <= 4'(fidx);
        end
        CMD_SCAN: begin
          if (sc_hit) begin
            rp_q         <= idx;
            next_valid_o <= 1'b1;
            next_run_o   <= 4'(idx);
          end else begin
            ptr_q <= scan_inc;
            cnt_q <= cnt_q + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/sync_ipc_rendezvous.sv @@
// Requests that are refused, find the caller busy or take an interrupt finish straight after
// decode; others may add the sendto chain walk, sender queue walk and round-robin scan, each
// stepping through the process table on the single table read port.
// One request at a time: start is taken again in the cycle after done_o.
// The receiver cannot stall: done_o lasts one cycle.
// Reset (rst_ni low, async) empties queues, clears modes and notes, slots_in_use 7, pointer 0.
`include "sync_ipc_rendezvous_macros.svh"

module sync_ipc_rendezvous import sir_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request transaction
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func_i,
  input  logic [3:0]           caller_i,
  input  logic [4:0]           peer_i,
  input  logic [ADDR_BITS-1:0] buf_addr_i,
  // configuration write: slots_in_use
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [4:0]           cfg_data_i,
  // result transaction, valid for the one cycle that done_o is high
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [ADDR_BITS-1:0] copy_from_o,
  output logic [ADDR_BITS-1:0] copy_to_o,
  output logic [4:0]           msg_source_o,
  output logic                 woken_valid_o,
  output logic [3:0]           woken_pid_o,
  output logic                 next_valid_o,
  output logic [3:0]           next_run_o
);

  cmd_e  cmd;
  stat_t stat;

  // Take a configuration write only while no request is in flight.
  assign cfg_ready_o = !busy;

  // Controller: sequence decode, chain walk, queue walk and scan steps.
  sir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Datapath: process tables, walk pointer and result registers.
  sir_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .caller_i      (caller_i),
    .peer_i        (peer_i),
    .buf_addr_i    (buf_addr_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .copy_from_o   (copy_from_o),
    .copy_to_o     (copy_to_o),
    .msg_source_o  (msg_source_o),
    .woken_valid_o (woken_valid_o),
    .woken_pid_o   (woken_pid_o),
    .next_valid_o  (next_valid_o),
    .next_run_o    (next_run_o)
  );

  // A result strobe lasts a single cycle.
  `SIR_ASSERT_NXT(a_done_pulse, done_o, !done_o, "done_o held for more than one cycle")
  // A taken request keeps the engine busy in the following cycle.
  `SIR_ASSERT_NXT(a_start_busy, start && !busy, busy, "request taken but engine not busy")
  // A wake only comes with a copy or an interrupt note.
  `SIR_ASSERT_IMP(a_woken_status, done_o && woken_valid_o,
                  status_o == RES_COPIED || status_o == RES_IRQ,
                  "woken process reported without a delivery")
  // A scheduling pick only follows a blocked caller.
  `SIR_ASSERT_IMP(a_next_status, done_o && next_valid_o, status_o == RES_BLOCKED,
                  "next slot reported without a blocked caller")

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import sir_pkg::*;

  // Timeout and settle counts, in clock cycles.
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 3 * NUM_PROCS + 12;

  // One result of the rendezvous engine, laid out as on the ports.
  typedef struct {
    logic [2:0]  status;
    logic [31:0] copy_from;
    logic [31:0] copy_to;
    logic [4:0]  msg_source;
    logic        woken_valid;
    logic [3:0]  woken_pid;
    logic        next_valid;
    logic [3:0]  next_run;
  } ipc_res_t;

  // One row of the directed stimulus; typed rows carry their own answer.
  typedef struct {
    logic [1:0]  func;
    logic [3:0]  caller;
    logic [4:0]  peer;
    logic [31:0] buf_addr;
    bit          typed;
    ipc_res_t    res;
  } req_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           func_i = FUNC_SEND;
  logic [3:0]           caller_i = '0;
  logic [4:0]           peer_i = '0;
  logic [ADDR_BITS-1:0] buf_addr_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [4:0]           cfg_data_i = '0;
  logic                 done_o;
  logic [2:0]           status_o;
  logic [ADDR_BITS-1:0] copy_from_o;
  logic [ADDR_BITS-1:0] copy_to_o;
  logic [4:0]           msg_source_o;
  logic                 woken_valid_o;
  logic [3:0]           woken_pid_o;
  logic                 next_valid_o;
  logic [3:0]           next_run_o;

  sync_ipc_rendezvous dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .caller_i, .peer_i, .buf_addr_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o, .status_o, .copy_from_o,
    .copy_to_o, .msg_source_o, .woken_valid_o, .woken_pid_o, .next_valid_o,
    .next_run_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the process table
  logic [4:0]  slots;
  mode_e       mode     [NUM_PROCS];
  logic [4:0]  target   [NUM_PROCS];
  logic [4:0]  filter   [NUM_PROCS];
  logic [31:0] park_buf [NUM_PROCS];
  logic [4:0]  q_head   [NUM_PROCS];
  logic [4:0]  q_link   [NUM_PROCS];
  bit          irq_note [NUM_PROCS];
  int          run_ptr;

  ipc_res_t pending_results[$];
  req_row_t directed[$];
  int       errors, cycles, accepted, delivered, blocked, refused, notes;
  bit       burst;

  function automatic void clear_table();
    for (int i = 0; i < NUM_PROCS; i++) begin
      mode[i] = MODE_IDLE;
      target[i] = ID_NONE;
      filter[i] = FILT_NONE;
      park_buf[i] = '0;
      q_head[i] = ID_NONE;
      q_link[i] = ID_NONE;
      irq_note[i] = 1'b0;
    end
    run_ptr = 0;
    slots = 5'd7;
  endfunction

  // Round-robin scan for the next idle slot below the slot limit.
  function automatic void pick_ready(inout ipc_res_t r);
    int lim;
    int c;
    lim = slots;
    if (lim < 1) lim = 1;
    if (lim > NUM_PROCS) lim = NUM_PROCS;
    for (int i = 1; i <= NUM_PROCS; i++) begin
      c = (run_ptr + i) % NUM_PROCS;
      if (c < lim && mode[c] == MODE_IDLE) begin
        run_ptr = c;
        r.next_valid = 1'b1;
        r.next_run = c[3:0];
        return;
      end
    end
  endfunction

  // Walk the sendto chain from dest; true when it leads back to from.
  function automatic bit closes_loop(int from, int dest);
    int p;
    p = dest;
    for (int n = 0; n < NUM_PROCS; n++) begin
      if (mode[p] != MODE_SEND) return 1'b0;
      if (target[p] == from) return 1'b1;
      if (target[p] >= NUM_PROCS) return 1'b0;
      p = target[p];
    end
    return 1'b0;
  endfunction

  function automatic void release_proc(int p, inout ipc_res_t r);
    mode[p] = MODE_IDLE;
    target[p] = ID_NONE;
    filter[p] = FILT_NONE;
    park_buf[p] = '0;
    r.woken_valid = 1'b1;
    r.woken_pid = p[3:0];
  endfunction

  // Work out the result of one request and advance the shadow table.
  function automatic ipc_res_t resolve_request(logic [1:0] f, logic [3:0] c_in,
                                               logic [4:0] pr, logic [31:0] b);
    ipc_res_t r;
    int c, d, p, prev, from;
    r = '{default: '0};
    c = c_in;
    d = pr;
    from = ID_NONE;
    if (f == FUNC_BAD) begin
      r.status = RES_REFUSED;
    end else if (f == FUNC_POST) begin
      if (mode[c] == MODE_RECV && (filter[c] == FILT_ANY || filter[c] == FILT_INT)) begin
        r.status = RES_IRQ;
        r.copy_to = park_buf[c];
        r.msg_source = SRC_INT;
        release_proc(c, r);
      end else begin
        irq_note[c] = 1'b1;
        r.status = RES_BLOCKED;
      end
    end else if (mode[c] != MODE_IDLE) begin
      r.status = RES_BLOCKED;
    end else if (f == FUNC_SEND) begin
      if (d == c || d >= NUM_PROCS) begin
        r.status = RES_REFUSED;
      end else if (closes_loop(c, d)) begin
        r.status = RES_DEAD;
      end else if (mode[d] == MODE_RECV && (filter[d] == c || filter[d] == FILT_ANY)) begin
        r.status = RES_COPIED;
        r.copy_from = b;
        r.copy_to = park_buf[d];
        r.msg_source = c[4:0];
        release_proc(d, r);
      end else begin
        // Park the caller at the tail of the destination's sender FIFO
        mode[c] = MODE_SEND;
        target[c] = d[4:0];
        park_buf[c] = b;
        q_link[c] = ID_NONE;
        if (q_head[d] >= NUM_PROCS) begin
          q_head[d] = c[4:0];
        end else begin
          p = q_head[d];
          for (int n = 0; n < NUM_PROCS && q_link[p] < NUM_PROCS; n++) p = q_link[p];
          q_link[p] = c[4:0];
        end
        r.status = RES_BLOCKED;
        pick_ready(r);
      end
    end else begin
      if (d == c || (d >= NUM_PROCS && pr != PEER_ANY && pr != PEER_INT)) begin
        r.status = RES_REFUSED;
        return r;
      end
      if (irq_note[c] && (pr == PEER_ANY || pr == PEER_INT)) begin
        irq_note[c] = 1'b0;
        r.status = RES_IRQ;
        r.copy_to = b;
        r.msg_source = SRC_INT;
        return r;
      end
      if (pr == PEER_ANY) begin
        if (q_head[c] < NUM_PROCS) from = q_head[c];
      end else if (d < NUM_PROCS) begin
        if (mode[d] == MODE_SEND && target[d] == c) from = d;
      end
      if (from < NUM_PROCS) begin
        // Unlink the chosen sender from the caller's FIFO
        p = q_head[c];
        prev = ID_NONE;
        for (int n = 0; n < NUM_PROCS && p < NUM_PROCS; n++) begin
          if (p == from) begin
            if (prev < NUM_PROCS) q_link[prev] = q_link[from];
            else q_head[c] = q_link[from];
            break;
          end
          prev = p;
          p = q_link[p];
        end
        q_link[from] = ID_NONE;
        r.status = RES_COPIED;
        r.copy_from = park_buf[from];
        r.copy_to = b;
        r.msg_source = from[4:0];
        release_proc(from, r);
      end else begin
        mode[c] = MODE_RECV;
        park_buf[c] = b;
        filter[c] = (pr == PEER_ANY) ? FILT_ANY : (pr == PEER_INT) ? FILT_INT : pr;
        r.status = RES_BLOCKED;
        pick_ready(r);
      end
    end
    return r;
  endfunction

  function automatic void add_row(logic [1:0] f, logic [3:0] c, logic [4:0] pr,
                                  logic [31:0] b, bit typed, logic [2:0] st,
                                  logic [31:0] cf, logic [31:0] ct, logic [4:0] src,
                                  logic wv, logic [3:0] wp, logic nv, logic [3:0] nr);
    req_row_t row;
    row.func = f;
    row.caller = c;
    row.peer = pr;
    row.buf_addr = b;
    row.typed = typed;
    row.res = '{st, cf, ct, src, wv, wp, nv, nr};
    directed.push_back(row);
  endfunction

  // Hold the request until the engine takes it, then queue its expected result.
  task automatic issue(logic [1:0] f, logic [3:0] c, logic [4:0] pr, logic [31:0] b,
                       bit typed, ipc_res_t typed_res);
    int gap;
    ipc_res_t r;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    caller_i <= c;
    peer_i <= pr;
    buf_addr_i <= b;
    do @(posedge clk_i); while (busy);
    r = resolve_request(f, c, pr, b);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    accepted++;
  endtask

  // Drain outstanding transactions so the register can be written safely.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slots(logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    slots = v;
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Result monitor: the strobe cannot be held off, so compare at every done.
  always @(posedge clk_i) begin
    ipc_res_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, status_o);
        check_field("copy_from", e.copy_from, copy_from_o);
        check_field("copy_to", e.copy_to, copy_to_o);
        check_field("msg_source", e.msg_source, msg_source_o);
        check_field("woken_valid", e.woken_valid, woken_valid_o);
        check_field("woken_pid", e.woken_pid, woken_pid_o);
        check_field("next_valid", e.next_valid, next_valid_o);
        check_field("next_run", e.next_run, next_run_o);
        case (status_o)
          RES_COPIED:  delivered++;
          RES_BLOCKED: blocked++;
          RES_IRQ:     notes++;
          default:     refused++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [4:0] slot_plan[8] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd7, 5'd3, 5'd12, 5'd16};
    logic [1:0] f;
    logic [3:0] c;
    logic [4:0] pr;
    int pool, pick;
    clear_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Refusals: bad function, self target, peers out of range
    add_row(FUNC_BAD, 4'd15, 5'd0, 32'h0, 1, RES_REFUSED, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SEND, 4'd3, 5'd3, 32'h1, 1, RES_REFUSED, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SEND, 4'd3, PEER_ANY, 32'h2, 1, RES_REFUSED, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_RECV, 4'd3, 5'd18, 32'h3, 1, RES_REFUSED, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_RECV, 4'd8, 5'd31, 32'h4, 1, RES_REFUSED, 0, 0, 0, 0, 0, 0, 0);
    // Interrupt note parked, then taken by a receive from the interrupt source
    add_row(FUNC_POST, 4'd5, 5'd0, 32'h0, 1, RES_BLOCKED, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_RECV, 4'd5, PEER_INT, 32'hFFFF_FFFF, 1, RES_IRQ, 0, 32'hFFFF_FFFF,
            SRC_INT, 0, 0, 0, 0);
    // Receiver waits for anyone; a send meets it
    add_row(FUNC_RECV, 4'd2, PEER_ANY, 32'h0000_00A0, 1, RES_BLOCKED, 0, 0, 0, 0, 0,
            1, 4'd1);
    add_row(FUNC_SEND, 4'd1, 5'd2, 32'hFFFF_FFFF, 1, RES_COPIED, 32'hFFFF_FFFF,
            32'h0000_00A0, 5'd1, 1, 4'd2, 0, 0);
    // Two-party loop refused
    add_row(FUNC_SEND, 4'd0, 5'd1, 32'h0000_0B00, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SEND, 4'd1, 5'd0, 32'h0000_0C00, 1, RES_DEAD, 0, 0, 0, 0, 0, 0, 0);
    // Build a sender FIFO and a chain, then a blocked caller retries
    add_row(FUNC_SEND, 4'd2, 5'd1, 32'h5555_5555, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SEND, 4'd4, 5'd2, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SEND, 4'd0, 5'd5, 32'h1234_5678, 1, RES_BLOCKED, 0, 0, 0, 0, 0, 0, 0);
    // Take a sender off the tail of the FIFO, then the head
    add_row(FUNC_RECV, 4'd1, 5'd2, 32'h0000_0D00, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_RECV, 4'd1, PEER_ANY, 32'h0000_0E00, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_RECV, 4'd2, 5'd4, 32'h0000_0F00, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Interrupt note delivered at once to a receiver waiting for anyone
    add_row(FUNC_RECV, 4'd6, PEER_ANY, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_POST, 4'd6, 5'd0, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Receiver waits for a named sender, which then arrives
    add_row(FUNC_RECV, 4'd7, 5'd1, 32'h0F0F_0F0F, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SEND, 4'd1, 5'd7, 32'hF0F0_F0F0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    burst = 1'b0;
    foreach (directed[i])
      issue(directed[i].func, directed[i].caller, directed[i].peer,
            directed[i].buf_addr, directed[i].typed, directed[i].res);

    // Random phases, each under its own slot limit
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_slots(slot_plan[ph]);
      burst = ($urandom_range(0, 3) == 0);
      pool = $urandom_range(3, 16);
      for (int k = 0; k < 250; k++) begin
        c = $urandom_range(0, pool - 1);
        pick = $urandom_range(0, 99);
        if (pick < 45) f = FUNC_SEND;
        else if (pick < 88) f = FUNC_RECV;
        else if (pick < 96) f = FUNC_POST;
        else f = FUNC_BAD;
        pick = $urandom_range(0, 99);
        if (pick < 75) pr = $urandom_range(0, pool - 1);
        else if (pick < 87) pr = PEER_ANY;
        else if (pick < 95) pr = PEER_INT;
        else pr = $urandom_range(0, 31);
        issue(f, c, pr, $urandom, 1'b0, '{default: '0});
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d requests over 8 slot limits: %0d copies, %0d blocks,",
             accepted, delivered, blocked);
    $display("%0d interrupt notes and %0d refusals checked.", notes, refused);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
